FILE: rtl/gbn_pkg.sv
// gbn_pkg: types, constants and weight table for the 9x9 border-normalized blur
// used by gbn_cell and gaussian_blur_9x9_border_norm
package gbn_pkg;

   localparam int unsigned WIN        = 9;
   localparam int unsigned STORE_ROWS = 8;
   localparam int unsigned SUM_W      = 19;
   localparam int unsigned WSUM_W     = 11;
   localparam int unsigned CFG_W      = 11;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [10:0] WIDTH_RESET  = 11'd640;
   localparam logic [10:0] HEIGHT_RESET = 11'd480;
   localparam logic [10:0] HEIGHT_CAP   = 11'd1024;

   // flat [dx][dy] table, last two dx rows zero
   localparam logic [6:0] WEIGHTS [81] = '{
      7'd1,  7'd4,  7'd7,  7'd10, 7'd7,  7'd4,  7'd1,
      7'd4,  7'd16, 7'd26, 7'd34, 7'd26, 7'd16, 7'd4,
      7'd7,  7'd26, 7'd41, 7'd52, 7'd41, 7'd26, 7'd7,
      7'd10, 7'd34, 7'd51, 7'd64, 7'd52, 7'd34, 7'd10,
      7'd16, 7'd40, 7'd59, 7'd70, 7'd59, 7'd40, 7'd13,
      7'd10, 7'd34, 7'd51, 7'd64, 7'd52, 7'd34, 7'd10,
      7'd7,  7'd26, 7'd41, 7'd52, 7'd41, 7'd26, 7'd7,
      7'd4,  7'd16, 7'd26, 7'd34, 7'd26, 7'd16, 7'd4,
      7'd1,  7'd4,  7'd7,  7'd10, 7'd7,  7'd4,  7'd1,
      7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
      7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
   };

   typedef struct packed {
      logic [7:0] pixel_in;
      logic       flush;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic       frame_last;
   } rsp_type;

   typedef logic [WIN-1:0][7:0] col_type;

   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [WSUM_W-1:0] wsum;
   } part_type;

   typedef struct packed {
      logic       shift;
      logic       clear;
      logic       mac;
      logic       pass;
      logic [3:0] dy;
      logic       row_ok;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SHIFT,
      ST_MAC,
      ST_COMB,
      ST_DIV,
      ST_OUT
   } state_type;

   function automatic logic [6:0] weight_at(input int unsigned dx, input logic [3:0] dy);
      logic [6:0] w;
      w = '0;
      for (int k = 0; k < 9; k++) begin
         if (dy == 4'(k)) w = WEIGHTS[dx*9 + k];
      end
      return w;
   endfunction

endpackage

FILE: rtl/gbn_cell.sv
// gbn_cell: one window column; holds 9 pixels, accumulates its weighted part
// depends on gbn_pkg
module gbn_cell #(
   parameter int unsigned DX = 0
) (
   input  logic                  clock,
   input  gbn_pkg::cell_ctl_type ctl,
   input  logic                  col_ok,
   input  gbn_pkg::col_type      col_in,
   output gbn_pkg::col_type      col_out,
   input  gbn_pkg::part_type     part_in,
   output gbn_pkg::part_type     part_out
);

   gbn_pkg::col_type  col_ff;
   gbn_pkg::part_type acc_ff;
   logic [6:0]        wt;
   logic [7:0]        pix;
   logic [14:0]       prod;

   always_comb begin
      wt   = gbn_pkg::weight_at(DX, ctl.dy);
      pix  = (ctl.dy < 4'(gbn_pkg::WIN)) ? col_ff[ctl.dy] : 8'd0;
      prod = 15'(wt) * 15'(pix);
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) col_ff <= col_in;
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (ctl.mac) begin
         if (ctl.row_ok && col_ok) begin
            acc_ff.sum  <= acc_ff.sum + gbn_pkg::SUM_W'(prod);
            acc_ff.wsum <= acc_ff.wsum + gbn_pkg::WSUM_W'(wt);
         end
      end else if (ctl.pass) begin
         acc_ff <= part_in;
      end
   end

   assign col_out  = col_ff;
   assign part_out = acc_ff;

endmodule

FILE: rtl/gaussian_blur_9x9_border_norm.sv
// gaussian_blur_9x9_border_norm: streaming 9x9 weighted blur, border renormalized
// depends on gbn_pkg and gbn_cell
//
//  channel  direction  handshake           payload
//  req      in         req_valid/req_stall gbn_pkg::req_type (pixel_in, flush)
//  rsp      out        rsp_valid/rsp_stall gbn_pkg::rsp_type (pixel_out, frame_last)
//  csr      in         csr_wr_en           csr_index, csr_wr_data
//
// an item without result runs the 8 row store reads and the column load
// an item with result adds 9 mac steps in the cells, 9 steps
// passing partial sums down the chain and an 8 step divider
// reset is synchronous; no clearing pass, the row store is read only where written
// a stalled result holds; the next item is taken while it waits
module gaussian_blur_9x9_border_norm #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gbn_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gbn_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [10:0]       csr_wr_data
);

   localparam int unsigned CW    = $clog2(MAX_WIDTH);
   localparam int unsigned EW    = (CW + 1 > 11) ? CW + 1 : 11;
   localparam int unsigned XW    = EW + 1;
   localparam int unsigned DW    = EW + 3;
   localparam int unsigned DEPTH = gbn_pkg::STORE_ROWS * MAX_WIDTH;
   localparam int unsigned AW    = $clog2(DEPTH);

   gbn_pkg::state_type state_ff, state_in;
   logic [3:0]   step_ff;

   logic [10:0]  width_cfg_ff, height_cfg_ff;
   logic [CW-1:0] in_col_ff, out_col_ff;
   logic [10:0]  in_row_ff;
   logic [9:0]   out_row_ff;
   logic [DW-1:0] lag_ff;

   logic [EW-1:0] eff_w, wcfg_ext;
   logic [10:0]  eff_h;
   logic [DW-1:0] thr;

   logic [CW-1:0] item_col_ff;
   logic [10:0]  item_row_ff;
   logic [7:0]   pix_ff;
   logic         has_out_ff, last_ff;
   logic [8:0]   rowmask_ff, colmask_ff;
   logic [8:0]   rowmask, colmask;

   logic [7:0]   mem [DEPTH];
   logic [7:0]   rd_ff;
   logic         rv_ff;
   gbn_pkg::col_type newcol_ff;

   logic [gbn_pkg::SUM_W-1:0]  sum_ff, cand;
   logic [gbn_pkg::WSUM_W-1:0] wsum_ff;
   logic [7:0]   quo_ff;
   logic [2:0]   sh;

   logic         rsp_valid_ff;
   gbn_pkg::rsp_type rsp_data_ff;
   logic         rsp_free;

   logic         accept, in_frame, proc, has_out, last;
   logic [EW-1:0] ncol, nocol;
   logic [11:0]  rt;
   logic         rt_ok;
   logic [AW-1:0] addr;
   logic         mem_we;

   gbn_pkg::cell_ctl_type ctl;
   gbn_pkg::col_type  col_bus  [10];
   gbn_pkg::part_type part_bus [10];

   // effective frame size
   always_comb begin
      wcfg_ext = EW'(width_cfg_ff);
      if (wcfg_ext == '0) eff_w = EW'(1);
      else if (wcfg_ext > EW'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
      else eff_w = wcfg_ext;
      if (height_cfg_ff == '0) eff_h = 11'd1;
      else if (height_cfg_ff > gbn_pkg::HEIGHT_CAP) eff_h = gbn_pkg::HEIGHT_CAP;
      else eff_h = height_cfg_ff;
      thr = (DW'(eff_w) << 2) + DW'(4);
   end

   always_comb begin
      accept   = req_valid && (state_ff == gbn_pkg::ST_IDLE);
      in_frame = in_row_ff < eff_h;
      proc     = accept && !(in_frame && req_data.flush);
      has_out  = (lag_ff >= thr) && (11'(out_row_ff) < eff_h);
      last     = (11'(out_row_ff) == eff_h - 11'd1) && (EW'(out_col_ff) == eff_w - EW'(1));
      ncol     = EW'(in_col_ff) + EW'(1);
      nocol    = EW'(out_col_ff) + EW'(1);
      for (int k = 0; k < 9; k++) begin
         rowmask[k] = ((12'(out_row_ff) + 12'(k)) >= 12'd4) &&
                      ((12'(out_row_ff) + 12'(k)) < (12'(eff_h) + 12'd4));
         colmask[k] = ((XW'(out_col_ff) + XW'(k)) >= XW'(4)) &&
                      ((XW'(out_col_ff) + XW'(k)) < (XW'(eff_w) + XW'(4)));
      end
   end

   // row store addressing
   always_comb begin
      rt     = 12'(item_row_ff) + 12'(step_ff);
      rt_ok  = (rt >= 12'd8) && (rt < (12'(eff_h) + 12'd8));
      addr   = AW'(rt[2:0]) * AW'(MAX_WIDTH) + AW'(item_col_ff);
      mem_we = (state_ff == gbn_pkg::ST_READ) && (step_ff == 4'd8) && (item_row_ff < eff_h);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbn_pkg::ST_IDLE:  if (proc) state_in = gbn_pkg::ST_READ;
         gbn_pkg::ST_READ:  if (step_ff == 4'd8) state_in = gbn_pkg::ST_SHIFT;
         gbn_pkg::ST_SHIFT: state_in = has_out_ff ? gbn_pkg::ST_MAC : gbn_pkg::ST_IDLE;
         gbn_pkg::ST_MAC:   if (step_ff == 4'd8) state_in = gbn_pkg::ST_COMB;
         gbn_pkg::ST_COMB:  if (step_ff == 4'd8) state_in = gbn_pkg::ST_DIV;
         gbn_pkg::ST_DIV:   if (step_ff == 4'd7) state_in = gbn_pkg::ST_OUT;
         gbn_pkg::ST_OUT:   if (rsp_free) state_in = gbn_pkg::ST_IDLE;
         default:           state_in = gbn_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      ctl        = '0;
      ctl.dy     = step_ff;
      ctl.row_ok = (step_ff < 4'd9) ? rowmask_ff[step_ff] : 1'b0;
      unique case (state_ff)
         gbn_pkg::ST_SHIFT: begin
            ctl.shift = 1'b1;
            ctl.clear = 1'b1;
         end
         gbn_pkg::ST_MAC:  ctl.mac  = 1'b1;
         gbn_pkg::ST_COMB: ctl.pass = 1'b1;
         default:          ctl.dy   = step_ff;
      endcase
      req_stall = state_ff != gbn_pkg::ST_IDLE;
      rsp_free  = !rsp_valid_ff || !rsp_stall;
      sh        = 3'(4'd7 - step_ff);
      cand      = gbn_pkg::SUM_W'(wsum_ff) << sh;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gbn_pkg::ST_IDLE;
         step_ff       <= '0;
         width_cfg_ff  <= gbn_pkg::WIDTH_RESET;
         height_cfg_ff <= gbn_pkg::HEIGHT_RESET;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         lag_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= (state_in != state_ff) ? 4'd0 : step_ff + 4'd1;
         if (csr_wr_en && (csr_index == gbn_pkg::CSR_FRAME_WIDTH ||
                           csr_index == gbn_pkg::CSR_FRAME_HEIGHT)) begin
            if (csr_index == gbn_pkg::CSR_FRAME_WIDTH) width_cfg_ff <= csr_wr_data;
            else height_cfg_ff <= csr_wr_data;
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
            lag_ff     <= '0;
         end else if (proc) begin
            if (has_out && last) begin
               in_col_ff  <= '0;
               in_row_ff  <= '0;
               out_col_ff <= '0;
               out_row_ff <= '0;
               lag_ff     <= '0;
            end else begin
               if (ncol >= eff_w) begin
                  in_col_ff <= '0;
                  in_row_ff <= in_row_ff + 11'd1;
               end else begin
                  in_col_ff <= CW'(ncol);
               end
               if (has_out) begin
                  if (nocol >= eff_w) begin
                     out_col_ff <= '0;
                     out_row_ff <= out_row_ff + 10'd1;
                  end else begin
                     out_col_ff <= CW'(nocol);
                  end
               end else begin
                  lag_ff <= lag_ff + DW'(1);
               end
            end
         end
         if ((state_ff == gbn_pkg::ST_OUT) && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // row store
   always_ff @(posedge clock) begin
      if (mem_we) mem[addr] <= pix_ff;
      rd_ff <= mem[addr];
   end

   // item datapath
   always_ff @(posedge clock) begin
      if (proc) begin
         item_col_ff <= in_col_ff;
         item_row_ff <= in_row_ff;
         pix_ff      <= req_data.pixel_in;
         has_out_ff  <= has_out;
         last_ff     <= has_out && last;
         rowmask_ff  <= rowmask;
         colmask_ff  <= colmask;
      end
      if (state_ff == gbn_pkg::ST_READ) begin
         rv_ff <= rt_ok;
         if (step_ff != 4'd0) newcol_ff[step_ff - 4'd1] <= rv_ff ? rd_ff : 8'd0;
         if (step_ff == 4'd8) newcol_ff[8] <= (item_row_ff < eff_h) ? pix_ff : 8'd0;
      end
      if (state_ff == gbn_pkg::ST_SHIFT) begin
         sum_ff  <= '0;
         wsum_ff <= '0;
      end else if (state_ff == gbn_pkg::ST_COMB) begin
         sum_ff  <= sum_ff + part_bus[0].sum;
         wsum_ff <= wsum_ff + part_bus[0].wsum;
      end else if (state_ff == gbn_pkg::ST_DIV) begin
         if (sum_ff >= cand) begin
            sum_ff <= sum_ff - cand;
            quo_ff <= {quo_ff[6:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[6:0], 1'b0};
         end
      end
      if ((state_ff == gbn_pkg::ST_OUT) && rsp_free) begin
         rsp_data_ff.pixel_out  <= quo_ff;
         rsp_data_ff.frame_last <= last_ff;
      end
   end

   // cell chain
   assign col_bus[9]  = newcol_ff;
   assign part_bus[9] = '0;

   for (genvar gi = 0; gi < 9; gi++) begin : g_cell
      gbn_cell #(
         .DX(gi)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .col_ok   (colmask_ff[gi]),
         .col_in   (col_bus[gi+1]),
         .col_out  (col_bus[gi]),
         .part_in  (part_bus[gi+1]),
         .part_out (part_bus[gi])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
